[hw/rtl/assert_macros.svh]
// Assertion macros used by the converter core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/fp8c_pkg.sv]
// Package: types and constants of the fp8 / fp32 converter.
package fp8c_pkg;

    localparam logic FMT_E5M2   = 1'b0;
    localparam logic FMT_E4M3FN = 1'b1;

    localparam logic REQ_DECODE = 1'b0;
    localparam logic REQ_ENCODE = 1'b1;

    localparam int BIAS32    = 127;
    localparam int BIAS_E5M2 = 15;
    localparam int BIAS_E4M3 = 7;
    localparam int MBITS_E5M2 = 2;
    localparam int MBITS_E4M3 = 3;

    localparam logic [7:0] EXP32_ALL_ONES = 8'hFF;

    // fp8 exponent to fp32 exponent
    localparam logic [7:0] ADJ_E5M2 = 8'(BIAS32 - BIAS_E5M2);
    localparam logic [7:0] ADJ_E4M3 = 8'(BIAS32 - BIAS_E4M3);
    // fp8 subnormal: fp32 exponent = msb position + this
    localparam logic [7:0] SUB_ADJ_E5M2 = 8'(BIAS32 - BIAS_E5M2 - MBITS_E5M2 + 1);
    localparam logic [7:0] SUB_ADJ_E4M3 = 8'(BIAS32 - BIAS_E4M3 - MBITS_E4M3 + 1);

    // encode limits on the fp32 biased exponent
    localparam logic [7:0]  OVF_EXP_E5M2 = 8'(BIAS32 + BIAS_E5M2);
    localparam logic [7:0]  OVF_EXP_E4M3 = 8'(BIAS32 + 8);
    localparam logic [22:0] OVF_FRAC_E4M3 = 23'h600000;
    localparam logic [7:0]  UNF_EXP_E5M2 = SUB_ADJ_E5M2;
    localparam logic [7:0]  UNF_EXP_E4M3 = SUB_ADJ_E4M3;
    localparam logic [7:0]  SUB_BASE_E5M2 = 8'(BIAS32 - BIAS_E5M2 + 1);
    localparam logic [7:0]  SUB_BASE_E4M3 = 8'(BIAS32 - BIAS_E4M3);

    localparam logic [6:0] NAN8_E5M2 = 7'h7D;
    localparam logic [6:0] NAN8_E4M3 = 7'h7F;
    localparam logic [6:0] INF8_E5M2 = 7'h7C;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INEXACT   = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_INF_UNSUP = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CL_NAN,
        CL_INF,
        CL_ZERO,
        CL_OVF,
        CL_UNF,
        CL_NORM,
        CL_SUB
    } t_enc_class;

    typedef struct packed {
        logic        req;
        logic        fmt;
        logic        sign;
        logic [7:0]  exp;
        logic [2:0]  fhi;
        logic        flo_zero;
        logic        f_zero;
        logic        f_gt_lim;
        logic [7:0]  code;
    } t_s1;

    typedef struct packed {
        logic        req;
        logic        fmt;
        logic        sign;
        logic [31:0] dec_bits;
        t_enc_class  cls;
        logic [1:0]  sub_k;
        logic [4:0]  exp_field;
        logic [2:0]  fhi;
        logic        flo_zero;
    } t_s2;

endpackage

[hw/rtl/fp8_fp32_exact_converter_core.sv]
// One item per cycle outside reset; three register stages, no stall path.
// busy is high only while reset is asserted; the result is shown for one cycle.
// Reset (synchronous, active low) clears all stage valid bits and sets the
// format register to E5M2.
// Top level of the fp8 / fp32 exact converter.
module fp8_fp32_exact_converter_core import fp8c_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_req_type,
    input  logic [31:0] i_operand_bits,
    output logic        o_valid,
    output logic [31:0] o_result_bits,
    output logic [2:0]  o_status
);

`include "assert_macros.svh"

    logic r_fp8_format;
    logic accept;
    logic s1_valid;
    t_s1  s1;
    logic s2_valid;
    t_s2  s2;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp8_format <= FMT_E5M2;
        end else if (i_cfg_we) begin
            r_fp8_format <= i_cfg_wdata;
        end
    end

    fp8c_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_fmt          (r_fp8_format),
        .i_req_type     (i_req_type),
        .i_operand_bits (i_operand_bits),
        .o_valid        (s1_valid),
        .o_s1           (s1)
    );

    fp8c_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_s1    (s1),
        .o_valid (s2_valid),
        .o_s2    (s2)
    );

    fp8c_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s2_valid),
        .i_s2          (s2),
        .o_valid       (o_valid),
        .o_result_bits (o_result_bits),
        .o_status      (o_status)
    );

    `ASSERT_IMPLY(a_latency, i_clk, i_rst_n, $past(i_rst_n, 1) && $past(i_rst_n, 2), o_valid == $past(accept, 3))
    `ASSERT_IMPLY(a_err_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK, o_result_bits == 32'd0)
    `ASSERT_IMPLY(a_decode_ok, i_clk, i_rst_n, o_valid && $past(i_req_type, 3) == REQ_DECODE, o_status == ST_OK)

endmodule

[hw/rtl/fp8c_front.sv]
// Stage 1: operand capture and fraction pre-checks.
module fp8c_front import fp8c_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_fmt,
    input  logic        i_req_type,
    input  logic [31:0] i_operand_bits,
    output logic        o_valid,
    output t_s1         o_s1
);

    logic r_valid;
    t_s1  r_s1;
    t_s1  n_s1;

    always_comb begin
        n_s1.req      = i_req_type;
        n_s1.fmt      = i_fmt;
        n_s1.sign     = i_operand_bits[31];
        n_s1.exp      = i_operand_bits[30:23];
        n_s1.fhi      = i_operand_bits[22:20];
        n_s1.flo_zero = (i_operand_bits[19:0] == 20'd0);
        n_s1.f_zero   = (i_operand_bits[22:0] == 23'd0);
        n_s1.f_gt_lim = (i_operand_bits[22:0] > OVF_FRAC_E4M3);
        n_s1.code     = i_operand_bits[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

[hw/rtl/fp8c_classify.sv]
// Stage 2: full fp8 decode and fp32 encode classification.
module fp8c_classify import fp8c_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_s1  i_s1,
    output logic o_valid,
    output t_s2  o_s2
);

    logic        r_valid;
    t_s2         r_s2;
    t_s2         n_s2;

    logic        d_sign;
    logic [7:0]  d_e8;
    logic [2:0]  d_m3;
    logic        d_special;
    logic [7:0]  d_ex;
    logic [22:0] d_frac;
    logic [31:0] d_bits;

    logic        fmt;
    logic [7:0]  e;
    t_enc_class  cls;
    logic        ovf;
    logic        unf;
    logic        norm;

    // decode
    always_comb begin
        fmt       = i_s1.fmt;
        d_sign    = i_s1.code[7];
        d_e8      = (fmt == FMT_E4M3FN) ? {4'd0, i_s1.code[6:3]} : {3'd0, i_s1.code[6:2]};
        d_m3      = (fmt == FMT_E4M3FN) ? i_s1.code[2:0] : {1'b0, i_s1.code[1:0]};
        d_special = (fmt == FMT_E4M3FN) ? (i_s1.code[6:0] == 7'h7F)
                                        : (i_s1.code[6:2] == 5'h1F);
        d_ex      = 8'd0;
        d_frac    = 23'd0;
        if (d_special) begin
            d_ex   = EXP32_ALL_ONES;
            d_frac = {20'd0, d_m3};
        end else if (d_e8 == 8'd0 && d_m3 == 3'd0) begin
            d_ex   = 8'd0;
            d_frac = 23'd0;
        end else if (d_e8 != 8'd0) begin
            d_ex   = d_e8 + ((fmt == FMT_E4M3FN) ? ADJ_E4M3 : ADJ_E5M2);
            d_frac = (fmt == FMT_E4M3FN) ? {d_m3, 20'd0} : {d_m3[1:0], 21'd0};
        end else if (d_m3[2]) begin
            d_ex   = 8'd2 + ((fmt == FMT_E4M3FN) ? SUB_ADJ_E4M3 : SUB_ADJ_E5M2);
            d_frac = {d_m3[1:0], 21'd0};
        end else if (d_m3[1]) begin
            d_ex   = 8'd1 + ((fmt == FMT_E4M3FN) ? SUB_ADJ_E4M3 : SUB_ADJ_E5M2);
            d_frac = {d_m3[0], 22'd0};
        end else begin
            d_ex   = (fmt == FMT_E4M3FN) ? SUB_ADJ_E4M3 : SUB_ADJ_E5M2;
            d_frac = 23'd0;
        end
        d_bits = {d_sign, d_ex, d_frac};
    end

    // encode classification
    always_comb begin
        e    = i_s1.exp;
        ovf  = (fmt == FMT_E4M3FN)
             ? (e > OVF_EXP_E4M3 || (e == OVF_EXP_E4M3 && i_s1.f_gt_lim))
             : (e > OVF_EXP_E5M2);
        unf  = (fmt == FMT_E4M3FN) ? (e < UNF_EXP_E4M3) : (e < UNF_EXP_E5M2);
        norm = (fmt == FMT_E4M3FN) ? (e > ADJ_E4M3) : (e > ADJ_E5M2);
        if (e == EXP32_ALL_ONES) begin
            cls = i_s1.f_zero ? CL_INF : CL_NAN;
        end else if (e == 8'd0 && i_s1.f_zero) begin
            cls = CL_ZERO;
        end else if (ovf) begin
            cls = CL_OVF;
        end else if (unf) begin
            cls = CL_UNF;
        end else if (norm) begin
            cls = CL_NORM;
        end else begin
            cls = CL_SUB;
        end
    end

    always_comb begin
        n_s2.req       = i_s1.req;
        n_s2.fmt       = fmt;
        n_s2.sign      = i_s1.sign;
        n_s2.dec_bits  = d_bits;
        n_s2.cls       = cls;
        n_s2.sub_k     = (fmt == FMT_E4M3FN) ? 2'(SUB_BASE_E4M3 - e) : 2'(SUB_BASE_E5M2 - e);
        n_s2.exp_field = (fmt == FMT_E4M3FN) ? 5'(e - ADJ_E4M3) : 5'(e - ADJ_E5M2);
        n_s2.fhi       = i_s1.fhi;
        n_s2.flo_zero  = i_s1.flo_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

[hw/rtl/fp8c_pack.sv]
// Stage 3: fp8 packing, exactness check and result register.
module fp8c_pack import fp8c_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_s2         i_s2,
    output logic        o_valid,
    output logic [31:0] o_result_bits,
    output logic [2:0]  o_status
);

    logic        r_valid;
    logic [31:0] r_result;
    t_status     r_status;
    logic [31:0] n_result;
    t_status     n_status;

    logic        e4;
    logic [6:0]  mag;
    logic        lost;
    t_status     enc_st;

    always_comb begin
        e4     = (i_s2.fmt == FMT_E4M3FN);
        mag    = 7'd0;
        lost   = 1'b0;
        enc_st = ST_OK;
        case (i_s2.cls)
            CL_NAN: begin
                mag = e4 ? NAN8_E4M3 : NAN8_E5M2;
            end
            CL_INF: begin
                if (e4) begin
                    enc_st = ST_INF_UNSUP;
                end else begin
                    mag = INF8_E5M2;
                end
            end
            CL_ZERO: begin
                mag = 7'd0;
            end
            CL_OVF: begin
                enc_st = ST_OVERFLOW;
            end
            CL_UNF: begin
                enc_st = ST_UNDERFLOW;
            end
            CL_NORM: begin
                lost = e4 ? !i_s2.flo_zero : !(i_s2.flo_zero && !i_s2.fhi[0]);
                mag  = e4 ? {i_s2.exp_field[3:0], i_s2.fhi}
                          : {i_s2.exp_field, i_s2.fhi[2:1]};
            end
            CL_SUB: begin
                lost = !(i_s2.flo_zero && !i_s2.fhi[0])
                     || (i_s2.sub_k != 2'd0 && i_s2.fhi[1])
                     || (i_s2.sub_k == 2'd2 && i_s2.fhi[2]);
                case (i_s2.sub_k)
                    2'd0:    mag = {4'd0, 1'b1, i_s2.fhi[2:1]};
                    2'd1:    mag = {5'd0, 1'b1, i_s2.fhi[2]};
                    default: mag = 7'd1;
                endcase
            end
            default: begin
                mag = 7'd0;
            end
        endcase
        if (lost) begin
            enc_st = ST_INEXACT;
        end

        if (i_s2.req == REQ_DECODE) begin
            n_result = i_s2.dec_bits;
            n_status = ST_OK;
        end else if (enc_st != ST_OK) begin
            n_result = 32'd0;
            n_status = enc_st;
        end else begin
            n_result = {24'd0, i_s2.sign, mag};
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_result <= n_result;
            r_status <= n_status;
        end
    end

    assign o_valid       = r_valid;
    assign o_result_bits = r_result;
    assign o_status      = r_status;

endmodule
